// ===== rtl/qss_pkg.sv =====
// qss_pkg: shared types, constants and the arctangent table for the
// fixed-point shortest-arc slerp pipeline. No dependencies.
`timescale 1ns / 1ps

package qss_pkg;

   localparam int STEPS     = 30;  // cordic micro-rotations
   localparam int ROOT_BITS = 31;  // square root result bits
   localparam int QUOT_BITS = 31;  // divider quotient bits
   localparam int ZW        = 34;  // cordic datapath width

   localparam logic [30:0] Q_ONE           = 31'h4000_0000;
   localparam logic [16:0] T_ONE           = 17'h1_0000;
   localparam logic [30:0] THRESHOLD_RESET = 31'd1074;
   localparam logic signed [ZW-1:0] INV_GAIN = 34'sd652032874;

   typedef struct packed {
      logic signed [31:0] a_w;
      logic signed [31:0] a_x;
      logic signed [31:0] a_y;
      logic signed [31:0] a_z;
      logic signed [31:0] b_w;
      logic signed [31:0] b_x;
      logic signed [31:0] b_y;
      logic signed [31:0] b_z;
      logic [16:0]        fraction;
   } req_word_type;

   typedef struct packed {
      logic signed [31:0] r_w;
      logic signed [31:0] r_x;
      logic signed [31:0] r_y;
      logic signed [31:0] r_z;
      logic               linear_used;
   } rsp_word_type;

   // operands that ride along the whole pipeline, index 0 is w
   typedef struct packed {
      logic [3:0][31:0] a;
      logic [3:0][32:0] b;
      logic [16:0]      t;
      logic             lin;
   } carry_type;

   // atan(2^-i) in Q2.30 radians
   function automatic logic signed [ZW-1:0] atan_val(input int unsigned idx);
      logic signed [ZW-1:0] v;
      case (idx)
         0:  v = 34'sd843314857;
         1:  v = 34'sd497837829;
         2:  v = 34'sd263043837;
         3:  v = 34'sd133525159;
         4:  v = 34'sd67021687;
         5:  v = 34'sd33543516;
         6:  v = 34'sd16775851;
         7:  v = 34'sd8388437;
         8:  v = 34'sd4194283;
         9:  v = 34'sd2097149;
         10: v = 34'sd1048576;
         11: v = 34'sd524288;
         12: v = 34'sd262144;
         13: v = 34'sd131072;
         14: v = 34'sd65536;
         15: v = 34'sd32768;
         16: v = 34'sd16384;
         17: v = 34'sd8192;
         18: v = 34'sd4096;
         19: v = 34'sd2048;
         20: v = 34'sd1024;
         21: v = 34'sd512;
         22: v = 34'sd256;
         23: v = 34'sd128;
         24: v = 34'sd64;
         25: v = 34'sd32;
         26: v = 34'sd16;
         27: v = 34'sd8;
         28: v = 34'sd4;
         29: v = 34'sd2;
         default: v = 34'sd0;
      endcase
      return v;
   endfunction

endpackage

// ===== rtl/quaternion_slerp_shortest_unit.sv =====
// Shortest-arc quaternion slerp in fixed point, fully pipelined.
// Depends on qss_pkg for word types, constants and the arctangent table.
`timescale 1ns / 1ps

// Takes one word per cycle while req_ready is high and returns one result
// word for each, in order, through these steps: the dot product, sign fix
// and squaring, the bit-per-stage square root giving sin(theta), the
// vectoring cordic giving theta, the two angle multiplies, the two rotation
// cordics giving the sines, the two bit-per-stage dividers, the weight
// multiplies and one output register. A one-word skid buffer behind the
// output register keeps req_ready registered; the whole pipeline halts only
// while that buffer is full.
// The threshold register takes writes at any time and applies to words
// whose third pipeline stage follows the write.
module quaternion_slerp_shortest_unit
   import qss_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_word_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_word_type rsp_data,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [30:0]  csr_data
);

   logic        en;
   logic [30:0] threshold_ff;
   logic        out_v_ff, out_v_in, skid_v_ff, skid_v_in;
   rsp_word_type out_ff, out_in, skid_ff, skid_in;

   assign en        = !skid_v_ff;
   assign req_ready = en;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESHOLD_RESET;
      end else if (csr_valid && csr_ready) begin
         threshold_ff <= csr_data;
      end
   end

   // ---------------- stage 1: four products
   logic [3:0][31:0] req_a, req_b;
   logic             p1_v_ff;
   carry_type        p1_c_ff, p1_c_in;
   logic [3:0][63:0] p1_prod_ff, p1_prod_in;

   assign req_a = {req_data.a_z, req_data.a_y, req_data.a_x, req_data.a_w};
   assign req_b = {req_data.b_z, req_data.b_y, req_data.b_x, req_data.b_w};

   always_comb begin
      p1_c_in.a = req_a;
      for (int k = 0; k < 4; k++) begin
         p1_c_in.b[k]  = {req_b[k][31], req_b[k]};
         p1_prod_in[k] = $signed(req_a[k]) * $signed(req_b[k]);
      end
      p1_c_in.t   = (req_data.fraction > T_ONE) ? T_ONE : req_data.fraction;
      p1_c_in.lin = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_v_ff <= 1'b0;
      end else if (en) begin
         p1_v_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p1_c_ff    <= p1_c_in;
         p1_prod_ff <= p1_prod_in;
      end
   end

   // ---------------- stage 2: sum and round to Q1.30
   logic signed [63:0] p2_sum, p2_round;
   logic               p2_v_ff;
   carry_type          p2_c_ff;
   logic [35:0]        p2_dot_ff, p2_dot_in;

   always_comb begin
      p2_sum = 64'sd0;
      for (int k = 0; k < 4; k++) begin
         p2_sum = p2_sum + ($signed(p1_prod_ff[k]) >>> 2);
      end
      p2_round  = p2_sum + 64'sd134217728;
      p2_dot_in = p2_round[63:28];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p2_v_ff <= 1'b0;
      end else if (en) begin
         p2_v_ff <= p1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p2_c_ff   <= p1_c_ff;
         p2_dot_ff <= p2_dot_in;
      end
   end

   // ---------------- stage 3 and square root: sin(theta) = sqrt(1 - dot^2)
   logic              sq_v_ff    [ROOT_BITS+1];
   carry_type         sq_c_ff    [ROOT_BITS+1];
   logic [29:0]       sq_d_ff    [ROOT_BITS+1];
   logic [60:0]       sq_rem_ff  [ROOT_BITS+1];
   logic [30:0]       sq_root_ff [ROOT_BITS+1];

   logic              p3_neg;
   logic [35:0]       p3_abs;
   logic signed [36:0] p3_gap;
   logic [59:0]       p3_sq;
   carry_type         p3_c_in;
   logic [60:0]       p3_rad_in;

   always_comb begin
      p3_neg  = p2_dot_ff[35];
      p3_abs  = p3_neg ? (36'd0 - p2_dot_ff) : p2_dot_ff;
      p3_gap  = $signed({6'd0, Q_ONE}) - $signed({1'b0, p3_abs});
      p3_c_in = p2_c_ff;
      p3_c_in.lin = (p3_gap <= $signed({6'd0, threshold_ff}));
      for (int k = 0; k < 4; k++) begin
         // shorter arc: flip the second quaternion
         p3_c_in.b[k] = p3_neg ? (33'd0 - p2_c_ff.b[k]) : p2_c_ff.b[k];
      end
      p3_sq     = p3_abs[29:0] * p3_abs[29:0];
      p3_rad_in = {1'b1, 60'd0} - {1'b0, p3_sq};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_v_ff[0] <= 1'b0;
      end else if (en) begin
         sq_v_ff[0] <= p2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sq_c_ff[0]    <= p3_c_in;
         sq_d_ff[0]    <= p3_abs[29:0];
         sq_rem_ff[0]  <= p3_rad_in;
         sq_root_ff[0] <= 31'd0;
      end
   end

   for (genvar k = 0; k < ROOT_BITS; k++) begin : g_sqrt
      localparam int BIT = ROOT_BITS - 1 - k;
      logic [62:0] trial;
      logic [60:0] rem_in;
      logic [30:0] root_in;

      always_comb begin
         trial = ({32'd0, sq_root_ff[k]} << (BIT + 1)) + (63'd1 << (2 * BIT));
         if ({2'b00, sq_rem_ff[k]} >= trial) begin
            rem_in  = sq_rem_ff[k] - trial[60:0];
            root_in = sq_root_ff[k] | (31'd1 << BIT);
         end else begin
            rem_in  = sq_rem_ff[k];
            root_in = sq_root_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            sq_v_ff[k+1] <= 1'b0;
         end else if (en) begin
            sq_v_ff[k+1] <= sq_v_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            sq_c_ff[k+1]    <= sq_c_ff[k];
            sq_d_ff[k+1]    <= sq_d_ff[k];
            sq_rem_ff[k+1]  <= rem_in;
            sq_root_ff[k+1] <= root_in;
         end
      end
   end

   // ---------------- vectoring cordic: theta = atan2(s, dot)
   logic                 vc_v_ff [STEPS];
   carry_type            vc_c_ff [STEPS];
   logic [30:0]          vc_s_ff [STEPS];
   logic signed [ZW-1:0] vc_x_ff [STEPS];
   logic signed [ZW-1:0] vc_y_ff [STEPS];
   logic signed [ZW-1:0] vc_z_ff [STEPS];

   for (genvar i = 0; i < STEPS; i++) begin : g_vec
      logic                 v0;
      carry_type            c0;
      logic [30:0]          s0;
      logic signed [ZW-1:0] x0, y0, z0, x_in, y_in, z_in;

      if (i == 0) begin : g_src
         assign v0 = sq_v_ff[ROOT_BITS];
         assign c0 = sq_c_ff[ROOT_BITS];
         assign s0 = sq_root_ff[ROOT_BITS];
         assign x0 = {4'd0, sq_d_ff[ROOT_BITS]};
         assign y0 = {3'd0, sq_root_ff[ROOT_BITS]};
         assign z0 = '0;
      end else begin : g_src
         assign v0 = vc_v_ff[i-1];
         assign c0 = vc_c_ff[i-1];
         assign s0 = vc_s_ff[i-1];
         assign x0 = vc_x_ff[i-1];
         assign y0 = vc_y_ff[i-1];
         assign z0 = vc_z_ff[i-1];
      end

      always_comb begin
         if (y0 > 0) begin
            x_in = x0 + (y0 >>> i);
            y_in = y0 - (x0 >>> i);
            z_in = z0 + atan_val(i);
         end else begin
            x_in = x0 - (y0 >>> i);
            y_in = y0 + (x0 >>> i);
            z_in = z0 - atan_val(i);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vc_v_ff[i] <= 1'b0;
         end else if (en) begin
            vc_v_ff[i] <= v0;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            vc_c_ff[i] <= c0;
            vc_s_ff[i] <= s0;
            vc_x_ff[i] <= x_in;
            vc_y_ff[i] <= y_in;
            vc_z_ff[i] <= z_in;
         end
      end
   end

   // ---------------- split angle: (1-t)theta and t theta
   logic                 an_v_ff;
   carry_type            an_c_ff;
   logic [30:0]          an_s_ff;
   logic signed [ZW-1:0] an_z_ff [2];
   logic signed [51:0]   an_pa, an_pb;

   always_comb begin
      an_pa = vc_z_ff[STEPS-1] * $signed({1'b0, T_ONE - vc_c_ff[STEPS-1].t});
      an_pb = vc_z_ff[STEPS-1] * $signed({1'b0, vc_c_ff[STEPS-1].t});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         an_v_ff <= 1'b0;
      end else if (en) begin
         an_v_ff <= vc_v_ff[STEPS-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         an_c_ff    <= vc_c_ff[STEPS-1];
         an_s_ff    <= vc_s_ff[STEPS-1];
         an_z_ff[0] <= an_pa[49:16];
         an_z_ff[1] <= an_pb[49:16];
      end
   end

   // ---------------- rotation cordics, lane 0 for a, lane 1 for b
   logic                 rt_v_ff [STEPS];
   carry_type            rt_c_ff [STEPS];
   logic [30:0]          rt_s_ff [STEPS];
   logic signed [ZW-1:0] rt_x_ff [STEPS][2];
   logic signed [ZW-1:0] rt_y_ff [STEPS][2];
   logic signed [ZW-1:0] rt_z_ff [STEPS][2];

   for (genvar i = 0; i < STEPS; i++) begin : g_rot
      logic                 v0;
      carry_type            c0;
      logic [30:0]          s0;
      logic signed [ZW-1:0] x0 [2];
      logic signed [ZW-1:0] y0 [2];
      logic signed [ZW-1:0] z0 [2];
      logic signed [ZW-1:0] x_in [2];
      logic signed [ZW-1:0] y_in [2];
      logic signed [ZW-1:0] z_in [2];

      if (i == 0) begin : g_src
         assign v0 = an_v_ff;
         assign c0 = an_c_ff;
         assign s0 = an_s_ff;
         for (genvar j = 0; j < 2; j++) begin : g_lane
            assign x0[j] = INV_GAIN;
            assign y0[j] = '0;
            assign z0[j] = an_z_ff[j];
         end
      end else begin : g_src
         assign v0 = rt_v_ff[i-1];
         assign c0 = rt_c_ff[i-1];
         assign s0 = rt_s_ff[i-1];
         for (genvar j = 0; j < 2; j++) begin : g_lane
            assign x0[j] = rt_x_ff[i-1][j];
            assign y0[j] = rt_y_ff[i-1][j];
            assign z0[j] = rt_z_ff[i-1][j];
         end
      end

      always_comb begin
         for (int j = 0; j < 2; j++) begin
            if (z0[j] >= 0) begin
               x_in[j] = x0[j] - (y0[j] >>> i);
               y_in[j] = y0[j] + (x0[j] >>> i);
               z_in[j] = z0[j] - atan_val(i);
            end else begin
               x_in[j] = x0[j] + (y0[j] >>> i);
               y_in[j] = y0[j] - (x0[j] >>> i);
               z_in[j] = z0[j] + atan_val(i);
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            rt_v_ff[i] <= 1'b0;
         end else if (en) begin
            rt_v_ff[i] <= v0;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rt_c_ff[i] <= c0;
            rt_s_ff[i] <= s0;
            for (int j = 0; j < 2; j++) begin
               rt_x_ff[i][j] <= x_in[j];
               rt_y_ff[i][j] <= y_in[j];
               rt_z_ff[i][j] <= z_in[j];
            end
         end
      end
   end

   // ---------------- divider setup: sine * 2^30 / s, clipped to 0 .. 1.0
   logic        dp_v_ff;
   carry_type   dp_c_ff;
   logic [30:0] dp_s_ff;
   logic [61:0] dp_rem_ff  [2];
   logic [61:0] dp_rem_in  [2];
   logic        dp_zero_ff [2];
   logic        dp_zero_in [2];
   logic        dp_over_ff [2];
   logic        dp_over_in [2];

   always_comb begin
      for (int j = 0; j < 2; j++) begin
         dp_zero_in[j] = (rt_y_ff[STEPS-1][j] <= 0);
         // quotient would reach 2.0 or more
         dp_over_in[j] = (rt_y_ff[STEPS-1][j] >= $signed({2'b00, rt_s_ff[STEPS-1], 1'b0}));
         dp_rem_in[j]  = {1'b0, rt_y_ff[STEPS-1][j][30:0], 30'd0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dp_v_ff <= 1'b0;
      end else if (en) begin
         dp_v_ff <= rt_v_ff[STEPS-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dp_c_ff <= rt_c_ff[STEPS-1];
         dp_s_ff <= rt_s_ff[STEPS-1];
         for (int j = 0; j < 2; j++) begin
            dp_rem_ff[j]  <= dp_rem_in[j];
            dp_zero_ff[j] <= dp_zero_in[j];
            dp_over_ff[j] <= dp_over_in[j];
         end
      end
   end

   // ---------------- restoring dividers, one quotient bit per stage
   logic        dv_v_ff    [QUOT_BITS];
   carry_type   dv_c_ff    [QUOT_BITS];
   logic [30:0] dv_s_ff    [QUOT_BITS];
   logic [61:0] dv_rem_ff  [QUOT_BITS][2];
   logic [30:0] dv_q_ff    [QUOT_BITS][2];
   logic        dv_zero_ff [QUOT_BITS][2];
   logic        dv_over_ff [QUOT_BITS][2];

   for (genvar k = 0; k < QUOT_BITS; k++) begin : g_div
      localparam int BIT = QUOT_BITS - 1 - k;
      logic        v0;
      carry_type   c0;
      logic [30:0] s0;
      logic [61:0] rem0   [2];
      logic [30:0] q0     [2];
      logic        zero0  [2];
      logic        over0  [2];
      logic [61:0] sub;
      logic [61:0] rem_in [2];
      logic [30:0] q_in   [2];

      if (k == 0) begin : g_src
         assign v0 = dp_v_ff;
         assign c0 = dp_c_ff;
         assign s0 = dp_s_ff;
         for (genvar j = 0; j < 2; j++) begin : g_lane
            assign rem0[j]  = dp_rem_ff[j];
            assign q0[j]    = '0;
            assign zero0[j] = dp_zero_ff[j];
            assign over0[j] = dp_over_ff[j];
         end
      end else begin : g_src
         assign v0 = dv_v_ff[k-1];
         assign c0 = dv_c_ff[k-1];
         assign s0 = dv_s_ff[k-1];
         for (genvar j = 0; j < 2; j++) begin : g_lane
            assign rem0[j]  = dv_rem_ff[k-1][j];
            assign q0[j]    = dv_q_ff[k-1][j];
            assign zero0[j] = dv_zero_ff[k-1][j];
            assign over0[j] = dv_over_ff[k-1][j];
         end
      end

      always_comb begin
         sub = {31'd0, s0} << BIT;
         for (int j = 0; j < 2; j++) begin
            if (rem0[j] >= sub) begin
               rem_in[j] = rem0[j] - sub;
               q_in[j]   = q0[j] | (31'd1 << BIT);
            end else begin
               rem_in[j] = rem0[j];
               q_in[j]   = q0[j];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_v_ff[k] <= 1'b0;
         end else if (en) begin
            dv_v_ff[k] <= v0;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            dv_c_ff[k] <= c0;
            dv_s_ff[k] <= s0;
            for (int j = 0; j < 2; j++) begin
               dv_rem_ff[k][j]  <= rem_in[j];
               dv_q_ff[k][j]    <= q_in[j];
               dv_zero_ff[k][j] <= zero0[j];
               dv_over_ff[k][j] <= over0[j];
            end
         end
      end
   end

   // ---------------- weights and the eight products
   logic [30:0]      wgt [2];
   carry_type        ml_src;
   logic             ml_v_ff, ml_lin_ff;
   logic [3:0][63:0] ml_pa_ff, ml_pa_in;
   logic [3:0][64:0] ml_pb_ff, ml_pb_in;

   assign ml_src = dv_c_ff[QUOT_BITS-1];

   always_comb begin
      for (int j = 0; j < 2; j++) begin
         if (dv_zero_ff[QUOT_BITS-1][j]) begin
            wgt[j] = '0;
         end else if (dv_over_ff[QUOT_BITS-1][j] || dv_q_ff[QUOT_BITS-1][j] > Q_ONE) begin
            wgt[j] = Q_ONE;
         end else begin
            wgt[j] = dv_q_ff[QUOT_BITS-1][j];
         end
      end
      if (ml_src.lin) begin
         wgt[0] = {T_ONE - ml_src.t, 14'd0};
         wgt[1] = {ml_src.t, 14'd0};
      end
      for (int k = 0; k < 4; k++) begin
         ml_pa_in[k] = $signed(ml_src.a[k]) * $signed({1'b0, wgt[0]});
         ml_pb_in[k] = $signed(ml_src.b[k]) * $signed({1'b0, wgt[1]});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ml_v_ff <= 1'b0;
      end else if (en) begin
         ml_v_ff <= dv_v_ff[QUOT_BITS-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ml_lin_ff <= ml_src.lin;
         ml_pa_ff  <= ml_pa_in;
         ml_pb_ff  <= ml_pb_in;
      end
   end

   // ---------------- round, saturate, output register and skid word
   function automatic logic signed [31:0] round_sat(input logic [63:0] pa,
                                                   input logic [64:0] pb);
      logic signed [65:0] sum;
      logic signed [35:0] r;
      sum = $signed({{2{pa[63]}}, pa}) + $signed({pb[64], pb}) + 66'sd536870912;
      r   = sum[65:30];
      if (r > 36'sd2147483647) begin
         return 32'sh7FFF_FFFF;
      end else if (r < -36'sd2147483648) begin
         return 32'sh8000_0000;
      end
      return r[31:0];
   endfunction

   logic         fin_v;
   rsp_word_type fin_word;

   assign fin_v = en && ml_v_ff;

   always_comb begin
      fin_word.r_w         = round_sat(ml_pa_ff[0], ml_pb_ff[0]);
      fin_word.r_x         = round_sat(ml_pa_ff[1], ml_pb_ff[1]);
      fin_word.r_y         = round_sat(ml_pa_ff[2], ml_pb_ff[2]);
      fin_word.r_z         = round_sat(ml_pa_ff[3], ml_pb_ff[3]);
      fin_word.linear_used = ml_lin_ff;
   end

   always_comb begin
      out_v_in  = out_v_ff;
      skid_v_in = skid_v_ff;
      out_in    = out_ff;
      skid_in   = skid_ff;
      if (!out_v_ff || rsp_ready) begin
         if (skid_v_ff) begin
            out_v_in  = 1'b1;
            out_in    = skid_ff;
            skid_v_in = 1'b0;
         end else begin
            out_v_in = fin_v;
            out_in   = fin_word;
         end
      end else if (fin_v) begin
         // output held, park the word
         skid_v_in = 1'b1;
         skid_in   = fin_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         out_v_ff  <= out_v_in;
         skid_v_ff <= skid_v_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid = out_v_ff;
   assign rsp_data  = out_ff;

   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |-> out_v_ff)
      else $error("skid word held with no output word");

   a_skid_fill: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_v_ff) |-> $past(out_v_ff && !rsp_ready))
      else $error("skid filled while output could drain");

   a_root_range: assert property (@(posedge clock) disable iff (reset)
      sq_v_ff[ROOT_BITS] |-> sq_root_ff[ROOT_BITS] <= Q_ONE)
      else $error("sine of angle above one");

   a_weight_range: assert property (@(posedge clock) disable iff (reset)
      dv_v_ff[QUOT_BITS-1] |-> (wgt[0] <= Q_ONE && wgt[1] <= Q_ONE))
      else $error("weight above one");

endmodule

// ===== tb/sv/quaternion_slerp_shortest_monitor.sv =====
// quaternion_slerp_shortest_monitor: watches the request, result and csr channels,
// predicts each slerp result and compares it with the block's output.
// Depends on qss_pkg for the word types, constants and the arctangent table.
`timescale 1ns / 1ps

module quaternion_slerp_shortest_monitor
   import qss_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_ready,
   input  req_word_type req_data,
   input  logic         rsp_valid,
   input  logic         rsp_ready,
   input  rsp_word_type rsp_data,
   input  logic         csr_valid,
   input  logic         csr_ready,
   input  logic [30:0]  csr_data,
   output int           mismatches,
   output int           outstanding,
   output int           words_checked,
   output int           linear_words
);

   rsp_word_type slerp_expect[$];
   logic [30:0]  threshold;

   function automatic longint unsigned root_floor(longint unsigned v);
      longint unsigned res, probe;
      res = 0;
      probe = 64'h1 << 62;
      while (probe > v) probe >>= 2;
      while (probe != 0) begin
         if (v >= res + probe) begin
            v -= res + probe;
            res = (res >> 1) + probe;
         end else begin
            res >>= 1;
         end
         probe >>= 2;
      end
      return res;
   endfunction

   function automatic longint arc_angle(longint x, longint y);
      longint z, dx, dy;
      z = 0;
      for (int i = 0; i < STEPS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y > 0) begin
            x += dx; y -= dy; z += longint'(atan_val(i));
         end else begin
            x -= dx; y += dy; z -= longint'(atan_val(i));
         end
      end
      return z;
   endfunction

   function automatic longint rotate_sine(longint z);
      longint x, y, dx, dy;
      x = longint'(INV_GAIN);
      y = 0;
      for (int i = 0; i < STEPS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx; y += dy; z -= longint'(atan_val(i));
         end else begin
            x += dx; y -= dy; z += longint'(atan_val(i));
         end
      end
      return y;
   endfunction

   function automatic longint sine_weight(longint sine, longint s);
      longint w;
      w = (sine * (longint'(1) << 30)) / s;
      if (w < 0) w = 0;
      if (w > (longint'(1) << 30)) w = longint'(1) << 30;
      return w;
   endfunction

   function automatic rsp_word_type predict_slerp(req_word_type q, logic [30:0] thr);
      longint a[4], b[4], sum, dot, t, wa, wb, s, theta, r;
      logic signed [31:0] res[4];
      rsp_word_type o;
      a[0] = q.a_w; a[1] = q.a_x; a[2] = q.a_y; a[3] = q.a_z;
      b[0] = q.b_w; b[1] = q.b_x; b[2] = q.b_y; b[3] = q.b_z;
      sum = 0;
      for (int k = 0; k < 4; k++) sum += (a[k] * b[k]) >>> 2;
      t = (q.fraction > T_ONE) ? longint'(T_ONE) : longint'(q.fraction);
      dot = (sum + (longint'(1) << 27)) >>> 28;
      if (dot < 0) begin
         dot = -dot;
         for (int k = 0; k < 4; k++) b[k] = -b[k];
      end
      o.linear_used = ((longint'(1) << 30) - dot) <= longint'(thr);
      if (o.linear_used) begin
         wa = (65536 - t) << 14;
         wb = t << 14;
      end else begin
         s = longint'(root_floor((64'h1 << 60) - longint'(dot * dot)));
         theta = arc_angle(dot, s);
         wa = sine_weight(rotate_sine((theta * (65536 - t)) >>> 16), s);
         wb = sine_weight(rotate_sine((theta * t) >>> 16), s);
      end
      for (int k = 0; k < 4; k++) begin
         r = (a[k] * wa + b[k] * wb + (longint'(1) << 29)) >>> 30;
         if (r > 64'sh7FFF_FFFF) r = 64'sh7FFF_FFFF;
         if (r < -64'sh8000_0000) r = -64'sh8000_0000;
         res[k] = r[31:0];
      end
      o.r_w = res[0]; o.r_x = res[1]; o.r_y = res[2]; o.r_z = res[3];
      return o;
   endfunction

   assign outstanding = slerp_expect.size();

   always @(posedge clock) begin
      rsp_word_type want;
      if (reset) begin
         threshold <= THRESHOLD_RESET;
         slerp_expect.delete();
         mismatches <= 0;
         words_checked <= 0;
         linear_words <= 0;
      end else begin
         if (csr_valid && csr_ready) threshold <= csr_data;
         if (req_valid && req_ready) slerp_expect.push_back(predict_slerp(req_data, threshold));
         if (rsp_valid && rsp_ready) begin
            words_checked <= words_checked + 1;
            if (rsp_data.linear_used) linear_words <= linear_words + 1;
            if (slerp_expect.size() == 0) begin
               if (mismatches < 10)
                  $display("%0t: result word with nothing expected: %h", $time, rsp_data);
               mismatches <= mismatches + 1;
            end else begin
               want = slerp_expect.pop_front();
               if (want !== rsp_data) begin
                  if (mismatches < 10)
                     $display("%0t: mismatch exp w=%h x=%h y=%h z=%h lin=%b got w=%h x=%h y=%h z=%h lin=%b",
                        $time, want.r_w, want.r_x, want.r_y, want.r_z, want.linear_used,
                        rsp_data.r_w, rsp_data.r_x, rsp_data.r_y, rsp_data.r_z,
                        rsp_data.linear_used);
                  mismatches <= mismatches + 1;
               end
            end
         end
      end
   end

endmodule

// ===== tb/sv/quaternion_slerp_shortest_unit_test.sv =====
// quaternion_slerp_shortest_unit_test: stimulus and verdict for the slerp unit.
// Depends on qss_pkg, quaternion_slerp_shortest_unit and quaternion_slerp_shortest_monitor.
`timescale 1ns / 1ps

module quaternion_slerp_shortest_unit_test
   import qss_pkg::*;
();

   logic         clock;
   logic         reset;
   logic         req_valid, req_ready, rsp_valid, rsp_ready, csr_valid, csr_ready;
   req_word_type req_data;
   rsp_word_type rsp_data;
   logic [30:0]  csr_data;
   int           mismatches, outstanding, words_checked, linear_words;
   int           send_idle, recv_idle, settings_used;

   quaternion_slerp_shortest_unit dut (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .rsp_valid, .rsp_ready, .rsp_data, .csr_valid, .csr_ready, .csr_data
   );

   quaternion_slerp_shortest_monitor monitor (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .rsp_valid, .rsp_ready, .rsp_data, .csr_valid, .csr_ready, .csr_data,
      .mismatches, .outstanding, .words_checked, .linear_words
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("timeout");
      $display("*** FAILED ***");
      $finish;
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle);
   end

   task automatic send_word(req_word_type w);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic write_threshold(logic [30:0] v);
      csr_valid <= 1'b1;
      csr_data <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (140) @(posedge clock);
   endtask

   // random unit quaternion in Q1.30
   task automatic unit_quat(output logic signed [31:0] c[4]);
      real v[4], n;
      n = 0.0;
      for (int k = 0; k < 4; k++) begin
         v[k] = ($urandom / 4294967295.0) * 2.0 - 1.0;
         n += v[k] * v[k];
      end
      n = $sqrt(n);
      if (n < 1.0e-3) begin
         v[0] = 1.0; n = 1.0;
      end
      for (int k = 0; k < 4; k++) c[k] = $rtoi(v[k] / n * 1073741824.0);
   endtask

   function automatic req_word_type pack_word(logic signed [31:0] a[4],
                                             logic signed [31:0] b[4], logic [16:0] t);
      req_word_type w;
      w.a_w = a[0]; w.a_x = a[1]; w.a_y = a[2]; w.a_z = a[3];
      w.b_w = b[0]; w.b_x = b[1]; w.b_y = b[2]; w.b_z = b[3];
      w.fraction = t;
      return w;
   endfunction

   task automatic random_word();
      logic signed [31:0] a[4], b[4];
      logic [16:0] t;
      int kind, sh;
      kind = $urandom_range(99);
      t = ($urandom_range(9) == 0) ? 17'($urandom) : 17'($urandom_range(65536));
      unit_quat(a);
      if (kind < 60) begin
         unit_quat(b);
      end else if (kind < 85) begin
         // neighbor or antipode of a, near the linear cutoff
         sh = $urandom_range(24);
         for (int k = 0; k < 4; k++) begin
            b[k] = a[k] + $signed($urandom_range(1 << sh)) - (1 << (sh - 1 > 0 ? sh - 1 : 0));
            if (kind >= 73) b[k] = -b[k];
         end
      end else begin
         for (int k = 0; k < 4; k++) begin
            a[k] = $urandom;
            b[k] = $urandom;
         end
      end
      send_word(pack_word(a, b, t));
   endtask

   initial begin
      logic signed [31:0] a[4], b[4], z[4], mx[4], mn[4];
      logic [30:0] thr_list[6];
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_data = '0;
      rsp_ready = 1'b0;
      send_idle = 0;
      recv_idle = 0;
      settings_used = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed words at the reset threshold
      for (int k = 0; k < 4; k++) begin
         z[k] = 0; mx[k] = 32'sh7FFF_FFFF; mn[k] = 32'sh8000_0000;
      end
      send_word(pack_word(z, z, 17'd0));
      send_word(pack_word(mx, mx, 17'd65536));
      send_word(pack_word(mn, mn, 17'h1FFFF));
      send_word(pack_word(mx, mn, 17'd32768));
      send_word(pack_word(mn, mx, 17'd1));
      unit_quat(a);
      send_word(pack_word(a, a, 17'd40000));
      for (int k = 0; k < 4; k++) b[k] = -a[k];
      send_word(pack_word(a, b, 17'd20000));
      a = '{32'sh4000_0000, 0, 0, 0};
      b = '{0, 32'sh4000_0000, 0, 0};
      send_word(pack_word(a, b, 17'd0));
      send_word(pack_word(a, b, 17'd65536));
      send_word(pack_word(a, b, 17'd32768));
      send_word(pack_word(a, b, 17'd65537));
      b = '{32'sh3FFF_FFF0, 32'sh0000_8000, 0, 0};
      send_word(pack_word(a, b, 17'd30000));
      b = '{32'shC000_0000, 0, 0, 0};
      send_word(pack_word(a, b, 17'd12345));
      b = '{32'sh2D41_3CCD, 0, 32'shD2BE_C333, 0};
      send_word(pack_word(a, b, 17'd50000));
      drain();

      thr_list = '{31'd0, 31'h4000_0000, 31'($urandom_range(1 << 20)),
                   31'h7FFF_FFFF, 31'($urandom), THRESHOLD_RESET};
      for (int seg = 0; seg < 6; seg++) begin
         case (seg / 2)
            0: begin send_idle = 36; recv_idle = 84; end
            1: begin send_idle = 84; recv_idle = 36; end
            default: begin send_idle = 0; recv_idle = 0; end
         endcase
         write_threshold(thr_list[seg]);
         for (int i = 0; i < 280; i++) begin
            if (seg == 4 && i == 140) begin
               // hold off until the pipeline has emptied
               req_valid <= 1'b0;
               @(posedge clock);
               while (outstanding != 0) @(posedge clock);
            end
            random_word();
         end
         drain();
      end

      $display("checked %0d result words, %0d on linear weights, %0d threshold settings",
               words_checked, linear_words, settings_used);
      if (mismatches == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

// ===== quaternion_slerp_shortest_unit.f =====
rtl/qss_pkg.sv
rtl/quaternion_slerp_shortest_unit.sv
tb/sv/quaternion_slerp_shortest_monitor.sv
tb/sv/quaternion_slerp_shortest_unit_test.sv
